// ===== rtl/cosh_taylor_series_macros.svh =====
// Assertion macros for the cosh Taylor series block.
// Used by cosh_taylor_series.sv; expects signals named clock and reset in scope.
`ifndef COSH_TAYLOR_SERIES_MACROS_SVH
`define COSH_TAYLOR_SERIES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
// Shared constants for the cosh Taylor series block.
// No dependencies; imported by cosh_taylor_series.
`default_nettype none

package cts_pkg;

   localparam int MAX_TERMS = 16;
   localparam int FRAC_BITS = 16;

   localparam int XW       = 16;
   localparam int MAG_W    = XW + 1;
   localparam int EPS_W    = 16;
   localparam int VAL_W    = 28;
   localparam int TERMS_W  = 7;
   localparam int SQ_SHIFT = 24 - FRAC_BITS;
   localparam int X2_W     = 31 - SQ_SHIFT;
   localparam int MPL_W    = (X2_W > MAG_W) ? X2_W : MAG_W;
   localparam int PROD_W   = VAL_W + MPL_W;
   localparam int DIV_W    = PROD_W - FRAC_BITS;
   localparam int CNT_W    = $clog2(DIV_W);
   localparam int N_W      = $clog2(2 * MAX_TERMS);
   localparam int DEN_W    = 2 * N_W;
   localparam int CMP_W    = VAL_W + EPS_W;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);
   localparam logic [VAL_W-1:0] VAL_MAX   = {VAL_W{1'b1}};
   localparam logic [VAL_W-1:0] ONE_VAL   = VAL_W'(1) << FRAC_BITS;
   localparam logic [DEN_W-1:0] FIRST_DEN = DEN_W'(2);
   localparam logic [DEN_W-1:0] DEN_STEP  = DEN_W'(10);

endpackage

`default_nettype wire

// ===== rtl/cosh_taylor_series.sv =====
// cosh(x) by Taylor series, bit-serial multiply and restoring divide.
// Depends on cts_pkg and cosh_taylor_series_macros.svh.
//
// Usage:
//   req_*  : one transaction carries x_value (signed Q4.12). Accepted when
//            req_valid is high and req_stall is low; req_stall is high while
//            an argument is being worked on.
//   rsp_*  : one transaction per argument: sum, last term, term count,
//            limit flag and saturation flag. rsp_valid holds until a cycle
//            with rsp_stall low; a pending result does not block the next
//            argument from starting.
//   csr_*  : write of epsilon (unsigned Q0.16); csr_ready is always high.
// Structure: one shared shift-add multiplier (MPL_W = 23 bits) and one
//   restoring divider (DIV_W = 35 bits). x is squared first; each further
//   term then takes a multiply, a divide and an update, with a check
//   before each term and a hand-off at the end. One argument at a time.
// Reset: synchronous, clears control state and sets epsilon to 7. If the
//   receiver stalls, the finished result waits in the DONE state until the
//   output register frees up.
`default_nettype none

`include "cosh_taylor_series_macros.svh"

module cosh_taylor_series (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [cts_pkg::XW-1:0] req_x_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cts_pkg::VAL_W-1:0]         rsp_series_sum,
   output logic [cts_pkg::VAL_W-1:0]         rsp_last_term,
   output logic [cts_pkg::TERMS_W-1:0]       rsp_terms_used,
   output logic                              rsp_limit_hit,
   output logic                              rsp_saturated,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cts_pkg::EPS_W-1:0]    csr_epsilon
);
   import cts_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQUARE = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_UPDATE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [EPS_W-1:0]      eps_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [VAL_W-1:0]      mcand_ff, mcand_in;
   logic [MPL_W-1:0]      mpl_ff, mpl_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [X2_W-1:0]       x2_ff, x2_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [VAL_W-1:0]      term_ff, term_in;
   logic [VAL_W-1:0]      sum_ff, sum_in;
   logic [TERMS_W-1:0]    terms_ff, terms_in;
   logic                  sat_ff, sat_in;
   logic                  lim_ff, lim_in;

   logic [VAL_W-1:0]      out_sum_ff, out_term_ff;
   logic [TERMS_W-1:0]    out_terms_ff;
   logic                  out_lim_ff, out_sat_ff;

   logic                  req_take, rsp_free, load_out, above, mul_last, div_last;
   logic [MAG_W-1:0]      mag;
   logic [PROD_W-1:0]     acc_step;
   logic [DEN_W:0]        div_trial;
   logic                  div_fits;
   logic [VAL_W-1:0]      next_term;
   logic                  next_clip;
   logic [VAL_W:0]        sum_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_DONE) && rsp_free;
   assign csr_ready = 1'b1;

   assign mag = req_x_value[XW-1] ? (MAG_W'(0) - {req_x_value[XW-1], req_x_value})
                                  : {1'b0, req_x_value};

   assign above = {term_ff, EPS_W'(0)} > (CMP_W'(eps_ff) << FRAC_BITS);

   assign acc_step = (acc_ff << 1) + (mpl_ff[MPL_W-1] ? PROD_W'(mcand_ff) : PROD_W'(0));
   assign mul_last = (cnt_ff == CNT_W'(MPL_W - 1));
   assign div_last = (cnt_ff == CNT_W'(DIV_W - 1));

   assign div_trial = {rem_ff, quo_ff[DIV_W-1]};
   assign div_fits  = div_trial >= {1'b0, den_ff};

   assign next_clip = |quo_ff[DIV_W-1:VAL_W];
   assign next_term = next_clip ? VAL_MAX : quo_ff[VAL_W-1:0];
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, next_term};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_in       = cnt_ff;
      mcand_in     = mcand_ff;
      mpl_in       = mpl_ff;
      acc_in       = acc_ff;
      x2_in        = x2_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      terms_in     = terms_ff;
      sat_in       = sat_ff;
      lim_in       = lim_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mcand_in = VAL_W'(mag);
               mpl_in   = MPL_W'(mag);
               acc_in   = '0;
               cnt_in   = '0;
               term_in  = ONE_VAL;
               sum_in   = ONE_VAL;
               n_in     = '0;
               den_in   = FIRST_DEN;
               terms_in = TERMS_W'(1);
               sat_in   = 1'b0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_in = acc_step;
            mpl_in = mpl_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (mul_last) begin
               x2_in    = X2_W'(acc_step >> SQ_SHIFT);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((terms_ff < TERMS_W'(MAX_TERMS)) && above) begin
               mcand_in = term_ff;
               mpl_in   = MPL_W'(x2_ff);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               lim_in   = above;
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            acc_in = acc_step;
            mpl_in = mpl_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (mul_last) begin
               quo_in   = DIV_W'(acc_step >> FRAC_BITS);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_fits ? DEN_W'(div_trial - {1'b0, den_ff}) : DEN_W'(div_trial);
            quo_in = {quo_ff[DIV_W-2:0], div_fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            term_in  = next_term;
            sum_in   = sum_wide[VAL_W] ? VAL_MAX : sum_wide[VAL_W-1:0];
            sat_in   = sat_ff || next_clip || sum_wide[VAL_W];
            den_in   = den_ff + DEN_W'({n_ff, 2'b00}) + DEN_STEP;
            n_in     = n_ff + N_W'(2);
            terms_in = terms_ff + TERMS_W'(1);
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= EPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            eps_ff <= csr_epsilon;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      mpl_ff   <= mpl_in;
      acc_ff   <= acc_in;
      x2_ff    <= x2_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      n_ff     <= n_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
      terms_ff <= terms_in;
      sat_ff   <= sat_in;
      lim_ff   <= lim_in;
      if (load_out) begin
         out_sum_ff   <= sum_ff;
         out_term_ff  <= term_ff;
         out_terms_ff <= terms_ff;
         out_lim_ff   <= lim_ff;
         out_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_series_sum = out_sum_ff;
   assign rsp_last_term  = out_term_ff;
   assign rsp_terms_used = out_terms_ff;
   assign rsp_limit_hit  = out_lim_ff;
   assign rsp_saturated  = out_sat_ff;

   `CTS_ASSERT_NEXT(a_start_square, req_take, state_ff == ST_SQUARE, "accepted x did not start squaring")
   `CTS_ASSERT_NEXT(a_update_to_check, state_ff == ST_UPDATE, state_ff == ST_CHECK, "term update did not return to check")
   `CTS_ASSERT_NOW(a_terms_range, rsp_valid, (rsp_terms_used != '0) && (rsp_terms_used <= TERMS_W'(MAX_TERMS)), "terms_used out of range")
   `CTS_ASSERT_NOW(a_limit_count, rsp_valid && rsp_limit_hit, rsp_terms_used == TERMS_W'(MAX_TERMS), "limit_hit without full term count")

endmodule

`default_nettype wire

// ===== verif/cosh_series_checker.sv =====
// Scoreboard for cosh_taylor_series: watches the csr, req and rsp channels,
// predicts each result from its own fixed-point Taylor series model and compares.
// Depends on cts_pkg for widths and constants; instantiated by testbench.
module cosh_series_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic signed [cts_pkg::XW-1:0] req_x_value,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [cts_pkg::VAL_W-1:0]     rsp_series_sum,
   input  wire logic [cts_pkg::VAL_W-1:0]     rsp_last_term,
   input  wire logic [cts_pkg::TERMS_W-1:0]   rsp_terms_used,
   input  wire logic                          rsp_limit_hit,
   input  wire logic                          rsp_saturated,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [cts_pkg::EPS_W-1:0]     csr_epsilon,
   output int                                 fail_count,
   output int                                 outstanding
);
   import cts_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0]   series_sum;
      logic [VAL_W-1:0]   last_term;
      logic [TERMS_W-1:0] terms_used;
      logic               limit_hit;
      logic               saturated;
   } cosh_result_t;

   cosh_result_t     expected_q[$];
   cosh_result_t     want;
   logic [EPS_W-1:0] eps_shadow;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      eps_shadow  = EPS_RESET;
   end

   // term in Q.FRAC_BITS against epsilon in Q0.16, exact
   function automatic bit term_above_eps(input logic [63:0] term, input logic [EPS_W-1:0] eps);
      return (term << 16) > (64'(eps) << FRAC_BITS);
   endfunction

   function automatic cosh_result_t cosh_series(input logic [XW-1:0] x_bits,
                                                input logic [EPS_W-1:0] eps);
      cosh_result_t res;
      logic [63:0]  mag;
      logic [63:0]  x_sq;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  idx;
      logic [63:0]  count;
      logic         sat;
      mag   = x_bits[XW-1] ? (64'h10000 - 64'(x_bits)) : 64'(x_bits);
      x_sq  = (mag * mag) >> SQ_SHIFT;
      term  = 64'(1) << FRAC_BITS;
      sum   = term;
      idx   = 0;
      count = 1;
      sat   = 1'b0;
      while (count < MAX_TERMS && term_above_eps(term, eps)) begin
         term = ((term * x_sq) >> FRAC_BITS) / ((idx + 1) * (idx + 2));
         if (term > 64'(VAL_MAX)) begin
            term = 64'(VAL_MAX);
            sat  = 1'b1;
         end
         sum = sum + term;
         if (sum > 64'(VAL_MAX)) begin
            sum = 64'(VAL_MAX);
            sat = 1'b1;
         end
         idx   = idx + 2;
         count = count + 1;
      end
      res.series_sum = sum[VAL_W-1:0];
      res.last_term  = term[VAL_W-1:0];
      res.terms_used = count[TERMS_W-1:0];
      res.limit_hit  = (count >= MAX_TERMS) && term_above_eps(term, eps);
      res.saturated  = sat;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      if (want_v !== got_v) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         eps_shadow = EPS_RESET;
         expected_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready)
            eps_shadow = csr_epsilon;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rsp transaction: sum 0x%0h", rsp_series_sum);
            end else begin
               want = expected_q.pop_front();
               compare_field("series_sum", 64'(want.series_sum), 64'(rsp_series_sum));
               compare_field("last_term", 64'(want.last_term), 64'(rsp_last_term));
               compare_field("terms_used", 64'(want.terms_used), 64'(rsp_terms_used));
               compare_field("limit_hit", 64'(want.limit_hit), 64'(rsp_limit_hit));
               compare_field("saturated", 64'(want.saturated), 64'(rsp_saturated));
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(cosh_series(req_x_value, eps_shadow));
         outstanding <= expected_q.size();
      end
   end
endmodule

// ===== verif/testbench.sv =====
// Top of the cosh_taylor_series regression: clock, reset, stimulus and verdict.
// Depends on cts_pkg, cosh_taylor_series and cosh_series_checker.
module testbench;
   import cts_pkg::*;

   localparam int HOLD_CYCLES = 3000;
   localparam int PHASE_ITEMS = 160;
   localparam int CYCLE_LIMIT = 6000000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [XW-1:0]   req_x_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [VAL_W-1:0]       rsp_series_sum;
   logic [VAL_W-1:0]       rsp_last_term;
   logic [TERMS_W-1:0]     rsp_terms_used;
   logic                   rsp_limit_hit;
   logic                   rsp_saturated;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [EPS_W-1:0]       csr_epsilon;
   int                     fail_count;
   int                     outstanding;
   int                     cycle_count = 0;
   int                     stall_left = 0;
   bit                     tx_bursty = 1'b0;
   bit                     rx_bursty = 1'b0;
   bit                     hold_go = 1'b0;
   logic [EPS_W-1:0]       eps_next;

   logic signed [XW-1:0] directed_x [0:19] = '{
      16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF, -16'sh8000, -16'sh7FFF, 16'sh1000,
      -16'sh1000, 16'sh0800, 16'sh2000, -16'sh3000, 16'sh4000, 16'sh6000, -16'sh6000,
      16'sh7000, 16'sh0100, 16'sh0010, 16'sh5555, -16'sh5556, 16'sh7F00
   };

   cosh_taylor_series uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_value(req_x_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_series_sum(rsp_series_sum), .rsp_last_term(rsp_last_term),
      .rsp_terms_used(rsp_terms_used), .rsp_limit_hit(rsp_limit_hit),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_epsilon(csr_epsilon)
   );

   cosh_series_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_value(req_x_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_series_sum(rsp_series_sum), .rsp_last_term(rsp_last_term),
      .rsp_terms_used(rsp_terms_used), .rsp_limit_hit(rsp_limit_hit),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_epsilon(csr_epsilon),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cosh_taylor_series regression: fail");
         $finish;
      end
   end

   // rsp side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go    = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && rx_bursty && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [XW-1:0] pick_x();
      int                   sel;
      logic signed [XW-1:0] v;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         v = XW'($urandom);
      end else if (sel < 7) begin
         v = XW'(int'($urandom_range(0, 2048)) - 1024);
      end else if (sel < 8) begin
         case ($urandom_range(0, 5))
            0: v = 16'sh0000;
            1: v = -16'sh8000;
            2: v = 16'sh7FFF;
            3: v = -16'sh7FFF;
            4: v = 16'sh0001;
            default: v = -16'sh0001;
         endcase
      end else begin
         v = XW'($urandom_range(16384, 32767));
         if ($urandom_range(0, 1) == 1)
            v = -v;
      end
      return v;
   endfunction

   task automatic offer_x(input logic signed [XW-1:0] x);
      int gap;
      if (tx_bursty && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [EPS_W-1:0] value);
      csr_valid   <= 1'b1;
      csr_epsilon <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_value = '0;
      csr_valid   = 1'b0;
      csr_epsilon = '0;
      repeat (9) @(posedge clock);
      reset     <= 1'b0;
      tx_bursty = 1'b1;
      rx_bursty = 1'b1;

      // directed: reset epsilon first, then zero epsilon on the extremes
      foreach (directed_x[i])
         offer_x(directed_x[i]);
      wait_drained();
      write_epsilon(16'd0);
      offer_x(16'sh0000);
      offer_x(16'sh7FFF);
      offer_x(-16'sh8000);
      offer_x(16'sh0001);

      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: eps_next = 16'hFFFF;
            1: eps_next = 16'd7;
            2: eps_next = 16'd1;
            3: eps_next = 16'hFFFE;
            4: eps_next = EPS_W'($urandom_range(0, 300));
            default: eps_next = EPS_W'($urandom);
         endcase
         write_epsilon(eps_next);
         if (phase == 2)
            hold_go = 1'b1;
         if (phase == 7) begin
            tx_bursty = 1'b0;
            rx_bursty = 1'b0;
         end
         repeat (PHASE_ITEMS) offer_x(pick_x());
      end

      wait_drained();
      repeat (1000) @(posedge clock);
      if (fail_count == 0)
         $display("cosh_taylor_series regression: pass");
      else
         $display("cosh_taylor_series regression: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cts_pkg.sv
rtl/cosh_taylor_series.sv
verif/cosh_series_checker.sv
verif/testbench.sv
